### rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned KindW       = 3;
  localparam int unsigned PosW        = 11;
  localparam int unsigned ValW        = 32;
  localparam int unsigned StatW       = 2;
  localparam int unsigned CntOutW     = 11;

  typedef enum logic [KindW-1:0] {
    KIND_READ = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_DRAIN,
    ST_WRITE,
    ST_SHRINK,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PosW-1:0]   position;
    logic signed [ValW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic [StatW-1:0]  status;
    logic [CntOutW-1:0] item_count;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic start_ins;
    logic start_del;
    logic shift;
    logic write_val;
    logic cnt_inc;
    logic cnt_dec;
    logic rd_op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    kind_e   kind;
    status_e code;
    logic    no_move;
    logic    last;
  } dp_stat_t;

endpackage

### rtl/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath
// Entry memory, count, shift pointers and result register.
// ----------------------------------------------------------------------------
module ils_datapath import ils_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > PosW) ? CW : PosW;

  logic [KindW-1:0] kind_q;
  logic [PosW-1:0]  pos_q;
  logic [ValW-1:0]  val_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, wa_q;
  logic             pend_q;
  status_e          status_q;
  logic             rdok_q;
  logic [ValW-1:0]  rdata_q;
  out_rsp_t         out_q;

  logic [ValW-1:0]  mem [CAPACITY];

  kind_e            kind;
  logic [XW-1:0]    pos_x, cnt_x, cnt_m1, pos_p1, ins_pos_x;
  logic [AW-1:0]    ins_pos;
  logic             full, is_del;
  status_e          st_code;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [ValW-1:0]  wdata;

  assign kind   = kind_e'(kind_q);
  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count_q);
  assign cnt_m1 = cnt_x - XW'(1);
  assign pos_p1 = pos_x + XW'(1);
  assign full   = (count_q == CW'(CAPACITY));
  assign is_del = (kind == KIND_DEL);

  always_comb begin
    unique case (kind)
      KIND_HEAD: ins_pos_x = '0;
      KIND_TAIL: ins_pos_x = cnt_x;
      default:   ins_pos_x = pos_x;
    endcase
  end
  assign ins_pos = ins_pos_x[AW-1:0];

  always_comb begin
    st_code = STAT_DONE;
    unique case (kind)
      KIND_READ: if (pos_x >= cnt_x) st_code = STAT_RANGE;
      KIND_HEAD, KIND_TAIL: if (full) st_code = STAT_FULL;
      KIND_AT: begin
        if (pos_x > cnt_x) st_code = STAT_RANGE;
        else if (full)     st_code = STAT_FULL;
      end
      KIND_DEL: if (pos_x >= cnt_x) st_code = STAT_RANGE;
      default: st_code = STAT_DONE;
    endcase
  end

  assign stat_o.kind    = kind;
  assign stat_o.code    = st_code;
  assign stat_o.no_move = is_del ? (pos_x == cnt_m1) : (ins_pos_x == cnt_x);
  assign stat_o.last    = is_del ? (ptr_q == cnt_m1[AW-1:0]) : (ptr_q == ins_pos);

  // one write port, one registered read port
  assign we    = pend_q | cmd_i.write_val;
  assign waddr = pend_q ? wa_q : ins_pos;
  assign wdata = pend_q ? rdata_q : val_q;
  assign re    = cmd_i.shift | cmd_i.rd_op;
  assign raddr = cmd_i.rd_op ? pos_x[AW-1:0] : ptr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) count_d = count_q + CW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= cmd_i.shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_req_i.kind;
      pos_q  <= in_req_i.position;
      val_q  <= in_req_i.value;
    end
    if (cmd_i.decide) begin
      status_q <= st_code;
      rdok_q   <= (kind == KIND_READ) && (st_code == STAT_DONE);
    end
    if (cmd_i.start_ins) begin
      ptr_q <= cnt_m1[AW-1:0];
    end else if (cmd_i.start_del) begin
      ptr_q <= pos_p1[AW-1:0];
    end else if (cmd_i.shift) begin
      ptr_q <= is_del ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
    end
    if (cmd_i.shift) begin
      wa_q <= is_del ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
    end
    if (cmd_i.load_out) begin
      out_q.read_value <= rdok_q ? rdata_q : '1;
      out_q.status     <= status_q;
      out_q.item_count <= cnt_x[CntOutW-1:0];
    end
  end

  assign out_rsp_o = out_q;

endmodule

### rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for decode, entry shifting, write-back and result handoff.
// ----------------------------------------------------------------------------
module ils_ctrl import ils_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (stat_i.code != STAT_DONE) begin
          state_d = ST_DONE;
        end else begin
          unique case (stat_i.kind)
            KIND_READ: state_d = ST_READ;
            KIND_HEAD, KIND_TAIL, KIND_AT:
              state_d = stat_i.no_move ? ST_WRITE : ST_SHIFT;
            KIND_DEL:  state_d = stat_i.no_move ? ST_SHRINK : ST_SHIFT;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SHIFT:  if (stat_i.last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = (stat_i.kind == KIND_DEL) ? ST_SHRINK : ST_WRITE;
      ST_WRITE:  state_d = ST_DONE;
      ST_SHRINK: state_d = ST_DONE;
      ST_READ:   state_d = ST_DONE;
      ST_DONE:   if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.decide = 1'b1;
        if (state_d == ST_SHIFT) begin
          cmd_o.start_del = (stat_i.kind == KIND_DEL);
          cmd_o.start_ins = (stat_i.kind != KIND_DEL);
        end
      end
      ST_SHIFT:  cmd_o.shift = 1'b1;
      ST_WRITE: begin
        cmd_o.write_val = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
      end
      ST_SHRINK: cmd_o.cnt_dec  = 1'b1;
      ST_READ:   cmd_o.rd_op    = 1'b1;
      ST_DONE:   cmd_o.load_out = slot_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded ordered list of signed 32-bit values with read, insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   in_req_i carries one request (kind, position, value) under
//   in_valid_i / in_ready_o; each request yields exactly one response
//   (read_value, status, item_count) on out_rsp_o under out_valid_o /
//   out_ready_i. One request is in flight at a time.
//   A rejected request or an unused kind goes from decode straight to the
//   response; a read or an insert/delete that moves nothing passes one
//   write, shrink or read state first; a positional insert or delete that
//   moves N entries, N <= CAPACITY - 1, shifts them and then drains the
//   last move before its write or shrink. The entry memory has one
//   registered read port and one write port: one entry moves per cycle.
//   in_ready_o rises on the edge that loads the response.
//   Reset empties the list (count zero); entry contents are not cleared.
//   When the receiver stalls, the response waits in the output register
//   and the next request is accepted and processed; its result is held
//   until the output register is free.
// ----------------------------------------------------------------------------
module indexed_list_store_top import ils_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

### rtl/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker import ils_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  localparam logic [CntOutW-1:0] FullCount = CntOutW'(CAPACITY);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STAT_FULL) |-> out_rsp_o.item_count == FullCount)
    else $error("full status with list not at capacity");

  a_reject_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != STAT_DONE) |-> out_rsp_o.read_value == '1)
    else $error("rejected request returned a value");

  a_busy_before_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response raised while ready for a request");

endmodule

bind indexed_list_store_top ils_checker #(
  .CAPACITY (CAPACITY)
) u_ils_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
